FILE: rtl/core/pulse_speed_odometer_defines.svh
// assertion macros for the pulse speed odometer
// used by rtl/core files that carry concurrent checks; clock clk_i, reset rst_ni
// empty bodies when SYNTHESIS is defined
`ifndef PULSE_SPEED_ODOMETER_DEFINES_SVH
`define PULSE_SPEED_ODOMETER_DEFINES_SVH

`ifndef SYNTHESIS
`define PSO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pso check failed");
`define PSO_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pso forbidden condition");
`else
`define PSO_ASSERT(lbl, prop)
`define PSO_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/core/pso_pkg.sv
// shared types and constants for the pulse speed odometer
// no dependencies; imported by pso_div, pulse_speed_odometer and the test files
`timescale 1ns / 1ps

package pso_pkg;

  localparam int unsigned DebW    = 16;
  localparam int unsigned TickW   = 10;
  localparam int unsigned WinW    = 16;
  localparam int unsigned PprW    = 10;
  localparam int unsigned UmW     = 20;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CntW    = 16;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned DistW   = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 72;

  // rpm dividend is pulses * 60, fits in 22 bits
  localparam int unsigned DivNumW = 22;
  localparam int unsigned DivDenW = PprW;
  localparam int unsigned DivCntW = 5;

  localparam logic [DebW-1:0]  DebRst  = 16'd5;
  localparam logic [TickW-1:0] TickRst = 10'd10;
  localparam logic [WinW-1:0]  WinRst  = 16'd100;
  localparam logic [PprW-1:0]  PprRst  = 10'd20;
  localparam logic [UmW-1:0]   UmRst   = 20'd5105;

  localparam logic [CntW-1:0] CntMax = 16'hFFFF;
  localparam logic [RpmW-1:0] RpmMax = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_TICK     = 3'd1,
    REG_WINDOW   = 3'd2,
    REG_PPR      = 3'd3,
    REG_UM       = 3'd4
  } pso_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_WIN,
    S_DIV,
    S_OUT
  } pso_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } pso_div_status_t;

endpackage

FILE: rtl/core/pulse_speed_odometer.sv
// pulse speed odometer: rpm and distance from a sampled encoder pin, one word per tick
// each tick word runs through the edge step, the window step, the serial divider on a
// window close with a nonzero ppr, and the output register; one tick at a time, so a new
// word is taken only after the last one has been handed to the output register
// reset (rst_ni, async low): registers to their defaults, all counters and odometer to zero
// depends on pso_pkg, pso_div and pulse_speed_odometer_defines.svh
`timescale 1ns / 1ps

`include "pulse_speed_odometer_defines.svh"

module pulse_speed_odometer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [pso_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pso_pkg::CfgW-1:0]      cfg_wdata_i,
  // tick words in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pso_pkg::InDataW-1:0]   s_axis_tdata_i,  // [0] pin_level, [7:1] zero
  // result words out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] wheel_rpm, [63:16] distance_um, [64] edge_counted, [65] window_closed, [71:66] zero
  output logic [pso_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import pso_pkg::*;

  // configuration registers
  logic [DebW-1:0]  deb_q;
  logic [TickW-1:0] tick_q;
  logic [WinW-1:0]  win_q;
  logic [PprW-1:0]  ppr_q;
  logic [UmW-1:0]   um_q;

  // tracking state
  logic [TimeW-1:0] time_q;
  logic [TimeW-1:0] last_q;
  logic             prev_q;
  logic [CntW-1:0]  pulses_q;
  logic [CntW-1:0]  wtc_q;
  logic [RpmW-1:0]  rpm_q;
  logic [DistW-1:0] dist_q;

  // per-tick scratch
  logic level_q;
  logic edge_q;
  logic closed_q;

  // output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  pso_state_e state_q, state_d;

  // sequencer strobes
  logic in_acc;
  logic upd_edge;
  logic upd_win;
  logic div_start;
  logic rpm_load;
  logic out_load;
  logic out_free;

  // datapath
  logic [TimeW-1:0]   time_n;
  logic [TimeW-1:0]   elapsed;
  logic               edge_hit;
  logic [CntW-1:0]    wtc_n;
  logic               close_hit;
  logic [DivNumW-1:0] rpm_num;
  logic [DivNumW-1:0] quo;
  logic [RpmW-1:0]    quo_sat;

  pso_div_status_t div_st;

  assign time_n   = time_q + TimeW'(tick_q);
  assign elapsed  = time_n - last_q;
  assign edge_hit = (level_q != prev_q) && (elapsed >= TimeW'(deb_q));

  assign wtc_n     = wtc_q + 1'b1;
  assign close_hit = wtc_n >= win_q;

  // pulses * 60 as (p << 6) - (p << 2)
  assign rpm_num = (DivNumW'(pulses_q) << 6) - (DivNumW'(pulses_q) << 2);
  assign quo_sat = (|quo[DivNumW-1:RpmW]) ? RpmMax : quo[RpmW-1:0];

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  pso_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (rpm_num),
    .den_i    (ppr_q),
    .status_o (div_st),
    .quo_o    (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: edge step, window step, optional divide, then hand off to the output word
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    upd_edge        = 1'b0;
    upd_win         = 1'b0;
    div_start       = 1'b0;
    rpm_load        = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        upd_edge = 1'b1;
        state_d  = S_WIN;
      end
      S_WIN: begin
        upd_win = 1'b1;
        // a zero divisor saturates directly without the divider
        if (close_hit && (ppr_q != '0)) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          rpm_load = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration and tracking registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DebRst;
      tick_q   <= TickRst;
      win_q    <= WinRst;
      ppr_q    <= PprRst;
      um_q     <= UmRst;
      time_q   <= '0;
      last_q   <= '0;
      prev_q   <= 1'b0;
      pulses_q <= '0;
      wtc_q    <= '0;
      rpm_q    <= '0;
      dist_q   <= '0;
      edge_q   <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE: deb_q  <= cfg_wdata_i[DebW-1:0];
          REG_TICK:     tick_q <= cfg_wdata_i[TickW-1:0];
          REG_WINDOW:   win_q  <= cfg_wdata_i[WinW-1:0];
          REG_PPR:      ppr_q  <= cfg_wdata_i[PprW-1:0];
          REG_UM:       um_q   <= cfg_wdata_i[UmW-1:0];
          default: ;
        endcase
      end
      if (upd_edge) begin
        time_q <= time_n;
        prev_q <= level_q;
        edge_q <= edge_hit;
        if (edge_hit) begin
          last_q <= time_n;
          dist_q <= dist_q + DistW'(um_q);
          if (pulses_q != CntMax) begin
            pulses_q <= pulses_q + 1'b1;
          end
        end
      end
      if (upd_win) begin
        closed_q <= close_hit;
        if (close_hit) begin
          // divider has captured the count, so the window restarts now
          pulses_q <= '0;
          wtc_q    <= '0;
          if (ppr_q == '0) begin
            rpm_q <= RpmMax;
          end
        end else begin
          wtc_q <= wtc_n;
        end
      end
      if (rpm_load) begin
        rpm_q <= quo_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      level_q <= s_axis_tdata_i[0];
    end
  end

  // output word register, kept apart from the input side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {6'b0, closed_q, edge_q, dist_q, rpm_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // checks on the sequencer and datapath
  `PSO_ASSERT(a_done_in_div, div_st.done |-> (state_q == S_DIV))
  `PSO_ASSERT_NEVER(a_no_overwrite, out_load && m_valid_q && !m_axis_tready_i)
  `PSO_ASSERT(a_dist_on_edge, !$stable(dist_q) |-> $past(upd_edge && edge_hit))
  `PSO_ASSERT(a_close_clears, (upd_win && close_hit) |=> (pulses_q == '0 && wtc_q == '0))

endmodule

FILE: rtl/core/pso_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on pso_pkg for widths and the status struct
`timescale 1ns / 1ps

module pso_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pso_pkg::DivNumW-1:0]   num_i,
  input  logic [pso_pkg::DivDenW-1:0]   den_i,
  output pso_pkg::pso_div_status_t      status_o,
  output logic [pso_pkg::DivNumW-1:0]   quo_o
);
  import pso_pkg::*;

  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  // remainder stays below the divisor, so it fits the divisor width
  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = DivCntW'(DivNumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = quo_q;

endmodule

FILE: test/pulse_speed_odometer_checker.sv
// checker for the pulse speed odometer: tracks register writes and tick words, keeps its
// own copy of the tachometer state and compares every result word field by field
// depends on pso_pkg for widths, reset values and register codes
`timescale 1ns / 1ps

module pulse_speed_odometer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pso_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pso_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [pso_pkg::InDataW-1:0]  s_axis_tdata_i,   // [0] pin_level, [7:1] zero
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  // [15:0] wheel_rpm, [63:16] distance_um, [64] edge_counted, [65] window_closed
  input  logic [pso_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           edges_o,
  output int                           closes_o,
  output logic                         saturated_o
);
  import pso_pkg::*;

  // packed msb first, so the layout matches the low 66 bits of the result word
  typedef struct packed {
    logic             win_closed;
    logic             edge_hit;
    logic [DistW-1:0] dist_um;
    logic [RpmW-1:0]  rpm;
  } odo_word_t;

  localparam int unsigned WordW = $bits(odo_word_t);
  localparam int unsigned MaxReports = 200;

  odo_word_t expected_words[$];

  logic [DebW-1:0]  min_gap_ms;
  logic [TickW-1:0] tick_ms;
  logic [WinW-1:0]  window_len;
  logic [PprW-1:0]  per_round;
  logic [UmW-1:0]   um_step;

  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] last_edge_ms;
  logic             level_q;
  logic [CntW-1:0]  win_pulses;
  logic [CntW-1:0]  win_ticks;
  logic [RpmW-1:0]  rpm_hold;
  logic [DistW-1:0] odo_um;

  int   errors;
  int   checked;
  int   edges;
  int   closes;
  logic saturated;

  function automatic logic [RpmW-1:0] rpm_of_window(input logic [CntW-1:0] pulses,
                                                    input logic [PprW-1:0] div);
    logic [31:0] q;
    if (div == '0) return RpmMax;
    q = ({16'd0, pulses} * 32'd60) / {22'd0, div};
    return (q > {16'd0, RpmMax}) ? RpmMax : q[RpmW-1:0];
  endfunction

  task automatic step_tick(input logic lvl);
    odo_word_t w;
    w = '0;
    now_ms = now_ms + {{(TimeW-TickW){1'b0}}, tick_ms};
    // elapsed time is modulo 2^32 by the width of the subtraction
    if (lvl != level_q && (now_ms - last_edge_ms) >= {{(TimeW-DebW){1'b0}}, min_gap_ms}) begin
      w.edge_hit = 1'b1;
      if (win_pulses != CntMax) win_pulses = win_pulses + 1'b1;
      odo_um = odo_um + {{(DistW-UmW){1'b0}}, um_step};
      last_edge_ms = now_ms;
    end
    level_q = lvl;
    win_ticks = win_ticks + 1'b1;
    if (win_ticks >= window_len) begin
      w.win_closed = 1'b1;
      rpm_hold = rpm_of_window(win_pulses, per_round);
      win_pulses = '0;
      win_ticks = '0;
    end
    w.rpm = rpm_hold;
    w.dist_um = odo_um;
    expected_words.push_back(w);
  endtask

  task automatic mismatch(input string field, input logic [DistW-1:0] want,
                          input logic [DistW-1:0] got);
    errors++;
    if (errors <= MaxReports)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic compare_word(input odo_word_t got);
    odo_word_t want;
    checked++;
    if (expected_words.size() == 0) begin
      errors++;
      $display("%0t: result word %h arrived with nothing outstanding", $time, got);
      return;
    end
    want = expected_words.pop_front();
    if (got.rpm !== want.rpm) mismatch("wheel_rpm", DistW'(want.rpm), DistW'(got.rpm));
    if (got.dist_um !== want.dist_um) mismatch("distance_um", want.dist_um, got.dist_um);
    if (got.edge_hit !== want.edge_hit)
      mismatch("edge_counted", DistW'(want.edge_hit), DistW'(got.edge_hit));
    if (got.win_closed !== want.win_closed)
      mismatch("window_closed", DistW'(want.win_closed), DistW'(got.win_closed));
    if (want.edge_hit) edges++;
    if (want.win_closed) closes++;
    if (want.win_closed && want.rpm == RpmMax) saturated = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_ms = DebRst;
      tick_ms = TickRst;
      window_len = WinRst;
      per_round = PprRst;
      um_step = UmRst;
      now_ms = '0;
      last_edge_ms = '0;
      level_q = 1'b0;
      win_pulses = '0;
      win_ticks = '0;
      rpm_hold = '0;
      odo_um = '0;
      expected_words.delete();
      errors = 0;
      checked = 0;
      edges = 0;
      closes = 0;
      saturated = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (pso_reg_e'(cfg_idx_i))
          REG_DEBOUNCE: min_gap_ms = cfg_wdata_i[DebW-1:0];
          REG_TICK:     tick_ms = cfg_wdata_i[TickW-1:0];
          REG_WINDOW:   window_len = cfg_wdata_i[WinW-1:0];
          REG_PPR:      per_round = cfg_wdata_i[PprW-1:0];
          REG_UM:       um_step = cfg_wdata_i[UmW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) step_tick(s_axis_tdata_i[0]);
      if (m_axis_tvalid_i && m_axis_tready_i) compare_word(odo_word_t'(m_axis_tdata_i[WordW-1:0]));
    end
    errors_o <= errors;
    pending_o <= expected_words.size();
    checked_o <= checked;
    edges_o <= edges;
    closes_o <= closes;
    saturated_o <= saturated;
  end

endmodule

FILE: test/pulse_speed_odometer_test.sv
// top of the pulse speed odometer testbench: clock, reset, register setup and tick stimulus
// with random idle bursts on both streams; the checker module does all prediction
// depends on pso_pkg, pulse_speed_odometer and pulse_speed_odometer_checker
`timescale 1ns / 1ps

module pulse_speed_odometer_test;
  import pso_pkg::*;

  // watchdog limit, far above the slowest correct run
  localparam int unsigned CycleLimit = 500000;
  // longer than a window-closing tick with a divide takes
  localparam int unsigned SettleCycles = 40;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_wdata;
  logic                tick_valid;
  logic                tick_ready;
  logic [InDataW-1:0]  tick_data;
  logic                word_valid;
  logic                word_ready;
  logic [OutDataW-1:0] word_data;

  int   err_count;
  int   pending;
  int   checked;
  int   edges;
  int   closes;
  logic saturated;

  // stimulus bookkeeping
  bit   idle_en;
  logic pin_now;
  int   ticks_sent;
  int   settings_used;

  pulse_speed_odometer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (tick_valid),
    .s_axis_tready_o (tick_ready),
    .s_axis_tdata_i  (tick_data),
    .m_axis_tvalid_o (word_valid),
    .m_axis_tready_i (word_ready),
    .m_axis_tdata_o  (word_data)
  );

  pulse_speed_odometer_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (tick_valid),
    .s_axis_tready_i (tick_ready),
    .s_axis_tdata_i  (tick_data),
    .m_axis_tvalid_i (word_valid),
    .m_axis_tready_i (word_ready),
    .m_axis_tdata_i  (word_data),
    .errors_o        (err_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .edges_o         (edges),
    .closes_o        (closes),
    .saturated_o     (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("** pulse_speed_odometer: FAILED **");
    $finish;
  end

  // result side: random stall bursts while idling is enabled
  initial begin
    word_ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 4) == 0) begin
        word_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      word_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // present one tick word and hold it until the handshake; valid stays high afterwards
  task automatic send_tick(input logic lvl);
    tick_valid <= 1'b1;
    tick_data <= {{(InDataW-1){1'b0}}, lvl};
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    pin_now = lvl;
    ticks_sent++;
  endtask

  // tick with an optional sender gap in front of it
  task automatic feed(input logic lvl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    send_tick(lvl);
  endtask

  // hold off the sender until every result is back, then let the block settle
  task automatic drain();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input pso_reg_e r, input logic [CfgW-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // full register set, one write per cycle; only called with the block idle
  task automatic program_regs(input logic [DebW-1:0] deb, input logic [TickW-1:0] tick,
                              input logic [WinW-1:0] win, input logic [PprW-1:0] ppr,
                              input logic [UmW-1:0] um);
    put_reg(REG_DEBOUNCE, CfgW'(deb));
    put_reg(REG_TICK, CfgW'(tick));
    put_reg(REG_WINDOW, CfgW'(win));
    put_reg(REG_PPR, CfgW'(ppr));
    put_reg(REG_UM, CfgW'(um));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0]       pat;
    logic [TickW-1:0] t;
    logic [DebW-1:0]  deb;
    logic [WinW-1:0]  win;
    logic [PprW-1:0]  ppr;
    logic [UmW-1:0]   um;
    int               len;
    int               pct;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_DEBOUNCE;
    cfg_wdata <= '0;
    tick_valid <= 1'b0;
    tick_data <= '0;
    idle_en = 1'b0;
    pin_now = 1'b0;
    ticks_sent = 0;
    settings_used = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults; a high pin on the very first tick must count as an edge
    pat = 8'b0100_1011;
    for (int i = 0; i < 8; i++) send_tick(pat[i]);
    drain();

    // no debounce, 1 ms ticks, every tick closes its window, largest step per pulse;
    // pulses on closing ticks belong to the window they close
    program_regs('0, 10'd1, 16'd1, 10'd1, 20'hFFFFF);
    pat = 8'b1001_0110;
    for (int i = 0; i < 8; i++) send_tick(pat[i]);
    drain();

    // debounce longer than two ticks drops fast toggles
    program_regs(16'd25, TickRst, 16'd50, PprRst, UmRst);
    pat = 8'b0010_1010;
    for (int i = 0; i < 6; i++) send_tick(pat[i]);
    drain();
    // window shortened below the ticks already seen closes on the next tick
    program_regs(16'd25, TickRst, 16'd3, PprRst, UmRst);
    pat = 8'b0000_1101;
    for (int i = 0; i < 4; i++) send_tick(pat[i]);
    drain();

    // random settings, extremes mixed in, each with a random toggle density
    while (ticks_sent < 300) begin
      case ($urandom_range(0, 5))
        0:       t = 10'd1;
        1:       t = 10'd1000;
        default: t = TickW'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       deb = '0;
        1:       deb = 16'hFFFF;
        2:       deb = DebW'($urandom);
        default: deb = DebW'($urandom_range(0, 3 * t));
      endcase
      case ($urandom_range(0, 5))
        0:       win = 16'd1;
        1:       win = 16'hFFFF;
        default: win = WinW'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       ppr = 10'd1;
        1:       ppr = 10'd1023;
        default: ppr = PprW'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 5))
        0:       um = '0;
        1:       um = 20'hFFFFF;
        default: um = UmW'($urandom);
      endcase
      program_regs(deb, t, win, ppr, um);
      idle_en = ($urandom_range(0, 3) != 0);
      len = $urandom_range(30, 90);
      pct = $urandom_range(5, 100);
      repeat (len) begin
        feed(($urandom_range(1, 100) <= pct) ? ~pin_now : pin_now);
        // occasional full drain with no register change
        if ($urandom_range(0, 59) == 0) drain();
      end
      drain();
    end

    // flush the open window with a one tick window, then one long window of
    // back to back pulses so rpm saturates at one pulse per round
    program_regs('0, TickW'($urandom_range(1, 1000)), 16'd1, 10'd1, UmW'($urandom));
    send_tick(~pin_now);
    drain();
    program_regs('0, TickW'($urandom_range(1, 1000)), 16'd1120, 10'd1, UmW'($urandom));
    repeat (1125) begin
      // last stretch runs with no idling on either side
      idle_en = (ticks_sent < 1250);
      feed(~pin_now);
    end
    drain();

    $display("covered %0d ticks under %0d register settings, %0d result words checked",
             ticks_sent, settings_used, checked);
    $display("%0d pulses counted, %0d windows closed, rpm saturation %s",
             edges, closes, saturated ? "reached" : "not reached");
    if (err_count == 0) begin
      $display("** pulse_speed_odometer: PASSED **");
    end else begin
      $display("** pulse_speed_odometer: FAILED **");
    end
    $finish;
  end

endmodule
